@@ rtl/hsn_pkg.sv @@
// shared types, constants and field layouts for the hangul syllable normalizer
package hsn_pkg;

    localparam int PT_W = 21;

    localparam logic [PT_W-1:0] SYL_BASE  = 21'h00AC00;
    localparam logic [PT_W-1:0] SYL_LAST  = 21'h00D7A3;
    localparam logic [PT_W-1:0] LEAD_BASE = 21'h001100;
    localparam logic [PT_W-1:0] LEAD_LAST = 21'h001112;
    localparam logic [PT_W-1:0] VOW_BASE  = 21'h001161;
    localparam logic [PT_W-1:0] VOW_LAST  = 21'h001175;
    localparam logic [PT_W-1:0] TRL_BASE  = 21'h0011A7;
    localparam logic [PT_W-1:0] TRL_LAST  = 21'h0011C2;

    localparam int VOW_CNT = 21;
    localparam int TRL_CNT = 28;

    // reciprocal constants: s / 28 for s < 11172, q / 21 for q < 399
    localparam int RECIP28 = 37450;
    localparam int SHIFT28 = 20;
    localparam int RECIP21 = 781;
    localparam int SHIFT21 = 14;

    localparam int SOFF_W = 14;  // syllable offset, below 11172
    localparam int Q28_W  = 9;   // offset / 28, below 399
    localparam int IDX_W  = 5;   // lead, vowel or trailing index

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [PT_W-1:0] code_point;
        logic            stream_end_in;
    } req_t;

    typedef struct packed {
        logic [PT_W-1:0] out_point;
        logic            run_last;
        logic            stream_end_out;
    } res_t;

    // one queued job: either a syllable to split or a list of up to two points
    typedef struct packed {
        logic             syl;
        logic [Q28_W-1:0] q28;
        logic [IDX_W-1:0] t_idx;
        logic [PT_W-1:0]  p0;
        logic [PT_W-1:0]  p1;
        logic [1:0]       cnt;
        logic             last_of_stream;
    } job_t;

endpackage

@@ rtl/hangul_syllable_normalizer_top.sv @@
// top level of the hangul syllable normalizer: front end, job queue and emitter
//
// request channel (req_valid/req_ready/req): one code point per request with an
// end-of-stream flag. result channel (res_valid/res_ready/res): one code point per
// result, run_last on the last result of a request, stream_end_out on the last
// result of the text. cfg_we/cfg_wdata writes the mode bit (0 decompose, 1 compose)
// at once; write it only while the block is idle.
// a request's job is queued; its results leave from the output register.
// throughput: one request per cycle; the emitter moves one result per cycle while
// the receiver keeps up, so a decomposed syllable holds it and the job queue
// (QUEUE_DEPTH jobs) takes the slack. a compose request that only joins makes no
// result and no job. req_ready drops only while the job queue is full.
// reset: decompose mode, nothing held, queue and output register empty.
// receiver stall: the output register holds its result, the emitter waits, the
// queue fills and then req_ready falls; nothing is lost or repeated.
module hangul_syllable_normalizer_top #(
    parameter int QUEUE_DEPTH = hsn_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    input  logic          req_valid,
    output logic          req_ready,
    input  hsn_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output hsn_pkg::res_t res
);

    logic          accept;
    logic          push;
    hsn_pkg::job_t push_job;
    logic          pop;
    logic          full;
    logic          empty;
    hsn_pkg::job_t head;

    // a request is taken whenever the queue has room for its job
    assign req_ready = !full;
    assign accept    = req_valid && req_ready;

    // classify, track the held point, build the job
    hsn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .req       (req),
        .push      (push),
        .job       (push_job)
    );

    // decouples intake from result emission
    hsn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head)
    );

    // one result per cycle into the output register while the receiver keeps up
    hsn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!empty),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule

@@ rtl/hsn_front.sv @@
// front end: mode register, request classification, compose hold state, job build
module hsn_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               accept,
    input  hsn_pkg::req_t      req,
    output logic               push,
    output hsn_pkg::job_t      job
);

    logic                       mode_reg;
    logic [hsn_pkg::PT_W-1:0]   held_point_reg, held_point_next;
    logic                       held_valid_reg, held_valid_next;
    logic                       held_lv_reg, held_lv_next;

    logic [hsn_pkg::PT_W-1:0]   ch;
    logic                       ch_syl, ch_v, ch_t, h_l;
    logic [hsn_pkg::SOFF_W-1:0] soff;
    logic [29:0]                prod28;
    logic [hsn_pkg::Q28_W-1:0]  q28;
    logic [hsn_pkg::SOFF_W-1:0] rem28;
    logic [hsn_pkg::IDX_W-1:0]  t_idx;
    logic                       ch_lv;
    logic [hsn_pkg::IDX_W-1:0]  hl, cv, ct;
    logic [hsn_pkg::Q28_W-1:0]  lv_idx;
    logic [hsn_pkg::SOFF_W-1:0] lv_off;
    logic                       join_lv, join_lvt, joined;
    logic [hsn_pkg::PT_W-1:0]   new_held;
    logic                       release_held;

    assign ch     = req.code_point;
    assign ch_syl = (ch >= hsn_pkg::SYL_BASE) && (ch <= hsn_pkg::SYL_LAST);
    assign ch_v   = (ch >= hsn_pkg::VOW_BASE) && (ch <= hsn_pkg::VOW_LAST);
    assign ch_t   = (ch > hsn_pkg::TRL_BASE) && (ch <= hsn_pkg::TRL_LAST);
    assign h_l    = (held_point_reg >= hsn_pkg::LEAD_BASE)
                 && (held_point_reg <= hsn_pkg::LEAD_LAST);

    // offset / 28 by reciprocal, remainder is the trailing index
    assign soff   = hsn_pkg::SOFF_W'(ch - hsn_pkg::SYL_BASE);
    assign prod28 = 30'(soff) * 30'(hsn_pkg::RECIP28);
    assign q28    = prod28[hsn_pkg::SHIFT28 +: hsn_pkg::Q28_W];
    assign rem28  = soff - hsn_pkg::SOFF_W'(q28) * hsn_pkg::SOFF_W'(hsn_pkg::TRL_CNT);
    assign t_idx  = rem28[hsn_pkg::IDX_W-1:0];
    assign ch_lv  = ch_syl && (t_idx == '0);

    // compose joins
    assign hl      = hsn_pkg::IDX_W'(held_point_reg - hsn_pkg::LEAD_BASE);
    assign cv      = hsn_pkg::IDX_W'(ch - hsn_pkg::VOW_BASE);
    assign ct      = hsn_pkg::IDX_W'(ch - hsn_pkg::TRL_BASE);
    assign lv_idx  = hsn_pkg::Q28_W'(hl) * hsn_pkg::Q28_W'(hsn_pkg::VOW_CNT)
                   + hsn_pkg::Q28_W'(cv);
    assign lv_off  = hsn_pkg::SOFF_W'(lv_idx) * hsn_pkg::SOFF_W'(hsn_pkg::TRL_CNT);
    assign join_lv  = held_valid_reg && h_l && ch_v;
    assign join_lvt = held_valid_reg && !join_lv && held_lv_reg && ch_t;
    assign joined   = join_lv || join_lvt;
    assign release_held = held_valid_reg && !joined;

    always_comb
    begin
        if (join_lv)
        begin
            new_held = hsn_pkg::SYL_BASE + hsn_pkg::PT_W'(lv_off);
        end
        else if (join_lvt)
        begin
            new_held = held_point_reg + hsn_pkg::PT_W'(ct);
        end
        else
        begin
            new_held = ch;
        end
    end

    always_comb
    begin
        held_point_next = held_point_reg;
        held_valid_next = held_valid_reg;
        held_lv_next    = held_lv_reg;
        push            = 1'b0;
        job             = '0;
        job.last_of_stream = req.stream_end_in;
        job.q28         = q28;
        job.t_idx       = t_idx;
        if (accept)
        begin
            if (!mode_reg)
            begin
                held_point_next = '0;
                held_valid_next = 1'b0;
                held_lv_next    = 1'b0;
                push            = 1'b1;
                job.syl         = ch_syl;
                job.p0          = ch;
                job.p1          = ch;
                if (ch_syl)
                begin
                    job.cnt = (t_idx != '0) ? 2'd3 : 2'd2;
                end
                else
                begin
                    job.cnt = 2'd1;
                end
            end
            else
            begin
                job.p0  = release_held ? held_point_reg : new_held;
                job.p1  = new_held;
                job.cnt = 2'(release_held) + 2'(req.stream_end_in);
                push    = release_held || req.stream_end_in;
                if (req.stream_end_in)
                begin
                    held_point_next = '0;
                    held_valid_next = 1'b0;
                    held_lv_next    = 1'b0;
                end
                else
                begin
                    held_point_next = new_held;
                    held_valid_next = 1'b1;
                    held_lv_next    = join_lv ? 1'b1 : (join_lvt ? 1'b0 : ch_lv);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            held_point_reg <= '0;
            held_valid_reg <= 1'b0;
            held_lv_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            held_point_reg <= held_point_next;
            held_valid_reg <= held_valid_next;
            held_lv_reg    <= held_lv_next;
        end
    end

endmodule

@@ rtl/hsn_queue.sv @@
// small job queue between the front end and the emitter
module hsn_queue #(
    parameter int DEPTH = hsn_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hsn_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output hsn_pkg::job_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hsn_pkg::job_t  slots_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/hsn_back.sv @@
// back end: expands one queued job into results, one per cycle unless res_ready stalls, into the output register
module hsn_back (
    input  logic          clk,
    input  logic          rst_n,
    input  hsn_pkg::job_t head,
    input  logic          head_valid,
    output logic          pop,
    output logic          res_valid,
    input  logic          res_ready,
    output hsn_pkg::res_t res
);

    logic [1:0]                 idx_reg, idx_next;
    logic                       res_valid_reg, res_valid_next;
    hsn_pkg::res_t              res_reg, res_next;
    logic                       load, last;
    logic [18:0]                prod21;
    logic [hsn_pkg::IDX_W-1:0]  l_idx, v_idx;
    logic [hsn_pkg::PT_W-1:0]   point;

    // lead index = offset / 28 / 21 by reciprocal, vowel index is the remainder
    assign prod21 = 19'(head.q28) * 19'(hsn_pkg::RECIP21);
    assign l_idx  = prod21[hsn_pkg::SHIFT21 +: hsn_pkg::IDX_W];
    assign v_idx  = hsn_pkg::IDX_W'(head.q28
                  - hsn_pkg::Q28_W'(l_idx) * hsn_pkg::Q28_W'(hsn_pkg::VOW_CNT));

    always_comb
    begin
        case (idx_reg)
            2'd0:    point = head.syl ? hsn_pkg::LEAD_BASE + hsn_pkg::PT_W'(l_idx) : head.p0;
            2'd1:    point = head.syl ? hsn_pkg::VOW_BASE + hsn_pkg::PT_W'(v_idx) : head.p1;
            default: point = hsn_pkg::TRL_BASE + hsn_pkg::PT_W'(head.t_idx);
        endcase
    end

    assign load = head_valid && (!res_valid_reg || res_ready);
    assign last = (idx_reg + 2'd1 == head.cnt);
    assign pop  = load && last;

    always_comb
    begin
        idx_next       = idx_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (load)
        begin
            res_valid_next         = 1'b1;
            res_next.out_point      = point;
            res_next.run_last       = last;
            res_next.stream_end_out = last && head.last_of_stream;
            idx_next                = last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ sim/tb_hangul_syllable_normalizer_top.sv @@
// self-checking testbench for the hangul syllable normalizer top level
module tb_hangul_syllable_normalizer_top;

    localparam int PW = hsn_pkg::PT_W;

    // hangul layout, in our own terms
    localparam int unsigned SYL_FIRST = 32'h0000AC00;
    localparam int unsigned L_FIRST   = 32'h00001100;
    localparam int unsigned V_FIRST   = 32'h00001161;
    localparam int unsigned T_ZERO    = 32'h000011A7;
    localparam int unsigned L_COUNT   = 19;
    localparam int unsigned V_COUNT   = 21;
    localparam int unsigned T_COUNT   = 28;
    localparam int unsigned VT_COUNT  = V_COUNT * T_COUNT;
    localparam int unsigned SYL_COUNT = L_COUNT * VT_COUNT;

    localparam logic MODE_DECOMPOSE = 1'b0;
    localparam logic MODE_COMPOSE   = 1'b1;

    localparam int SETTLE_CYCLES = 4;     // quiet time before a mode write
    localparam int TAIL_CYCLES   = 20;    // quiet time before the verdict
    localparam int STALL_LIMIT   = 1000;  // cycles with no transfer at all
    localparam int REPORT_MAX    = 10;

    typedef enum logic [1:0] { ACT_REQ, ACT_IDLE, ACT_CFG } act_kind_t;
    typedef enum logic [1:0] { STALL_NONE, STALL_LIGHT, STALL_HEAVY } stall_style_t;

    typedef struct {
        act_kind_t      kind;
        hsn_pkg::req_t  item;
        logic           mode;
    } stim_op_t;

    // clock, reset and dut ports; every input starts at a known value
    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic          cfg_wdata = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    hsn_pkg::req_t req = '0;
    logic          res_valid;
    logic          res_ready = 1'b0;
    hsn_pkg::res_t res;

    // stimulus and expectation stores
    stim_op_t      pending_ops[$];
    hsn_pkg::res_t expected_points[$];
    int            stim_count = 0;

    // shadow of the block: mode register and the one held code point
    logic          compose_mode = MODE_DECOMPOSE;
    logic [PW-1:0] held_cp = '0;
    logic          held_live = 1'b0;

    // driver and receiver bookkeeping
    logic          req_fired = 1'b0;
    int            burst_left = 1;
    int            gap_left = 0;
    int            settle_left = SETTLE_CYCLES;
    logic          nxt_valid;
    logic          nxt_we;
    stall_style_t  stall_style = STALL_NONE;
    int            stall_left = 0;
    int            stall_clock = 0;

    int            fault_count = 0;
    int            quiet_cycles = 0;
    hsn_pkg::res_t want;

    hangul_syllable_normalizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction: one accepted request in, zero to three code points out
    // ------------------------------------------------------------------
    function automatic void normalize_point(input hsn_pkg::req_t r);
        logic [PW-1:0] outs[3];
        int            n;
        int unsigned   ch;
        int unsigned   h;
        int unsigned   s;
        logic          joined;
        hsn_pkg::res_t e;
        n = 0;
        joined = 1'b0;
        ch = 32'(r.code_point);
        if (compose_mode == MODE_DECOMPOSE)
        begin
            // decompose drops whatever a previous compose phase left held
            held_live = 1'b0;
            held_cp = '0;
            if (ch >= SYL_FIRST && ch - SYL_FIRST < SYL_COUNT)
            begin
                s = ch - SYL_FIRST;
                outs[0] = PW'(L_FIRST + s / VT_COUNT);
                outs[1] = PW'(V_FIRST + (s % VT_COUNT) / T_COUNT);
                n = 2;
                if (s % T_COUNT != 0)
                begin
                    outs[2] = PW'(T_ZERO + s % T_COUNT);
                    n = 3;
                end
            end
            else
            begin
                outs[0] = r.code_point;
                n = 1;
            end
        end
        else
        begin
            if (held_live)
            begin
                h = 32'(held_cp);
                // lead + vowel gives an lv syllable
                if (h >= L_FIRST && h - L_FIRST < L_COUNT &&
                    ch >= V_FIRST && ch - V_FIRST < V_COUNT)
                begin
                    held_cp = PW'(SYL_FIRST +
                                  ((h - L_FIRST) * V_COUNT + (ch - V_FIRST)) * T_COUNT);
                    joined = 1'b1;
                end
                // lv syllable + real trailing consonant gives lvt; u+11a7 never joins
                else if (h >= SYL_FIRST && h - SYL_FIRST < SYL_COUNT &&
                         (h - SYL_FIRST) % T_COUNT == 0 &&
                         ch > T_ZERO && ch - T_ZERO < T_COUNT)
                begin
                    held_cp = PW'(h + (ch - T_ZERO));
                    joined = 1'b1;
                end
            end
            if (!joined)
            begin
                if (held_live)
                begin
                    outs[n] = held_cp;
                    n++;
                end
                held_cp = r.code_point;
                held_live = 1'b1;
            end
            if (r.stream_end_in)
            begin
                outs[n] = held_cp;
                n++;
                held_cp = '0;
                held_live = 1'b0;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            e.out_point = outs[i];
            e.run_last = (i == n - 1);
            e.stream_end_out = (i == n - 1) && r.stream_end_in;
            expected_points.push_back(e);
        end
    endfunction

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_req(input int unsigned cp, input logic last);
        stim_op_t op;
        op.kind = ACT_REQ;
        op.item.code_point = PW'(cp);
        op.item.stream_end_in = last;
        op.mode = 1'b0;
        pending_ops.push_back(op);
        stim_count++;
    endfunction

    // a mode write always waits for the block to drain first
    function automatic void add_mode_write(input logic m);
        stim_op_t op;
        op.item = '0;
        op.mode = m;
        op.kind = ACT_IDLE;
        pending_ops.push_back(op);
        op.kind = ACT_CFG;
        pending_ops.push_back(op);
    endfunction

    function automatic int unsigned any_point();
        case ($urandom_range(0, 4))
            0: any_point = $urandom_range(0, 32'h7F);
            1: any_point = $urandom_range(0, 32'hFFFF);
            2: any_point = $urandom_range(0, 32'h10FFFF);
            3: any_point = $urandom_range(32'h110000, 32'h1FFFFF);  // beyond unicode
            default: any_point = $urandom_range(32'h10F0, 32'h11FF); // around the jamo
        endcase
    endfunction

    function automatic int unsigned any_syllable();
        case ($urandom_range(0, 9))
            0: any_syllable = SYL_FIRST;
            1: any_syllable = SYL_FIRST + SYL_COUNT - 1;
            default: any_syllable = SYL_FIRST + $urandom_range(0, SYL_COUNT - 1);
        endcase
    endfunction

    function automatic logic rare_end();
        rare_end = ($urandom_range(0, 9) == 0);
    endfunction

    // mostly well formed jamo runs, some precomposed lv + t, some noise
    function automatic void queue_compose_run(input int goal);
        int pick;
        while (stim_count < goal)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
            begin
                add_req(L_FIRST + $urandom_range(0, L_COUNT - 1), 1'b0);
                add_req(V_FIRST + $urandom_range(0, V_COUNT - 1), rare_end());
                if ($urandom_range(0, 9) < 7)
                    add_req(T_ZERO + $urandom_range(1, T_COUNT - 1), rare_end());
            end
            else if (pick <= 7)
            begin
                add_req(SYL_FIRST + $urandom_range(0, L_COUNT * V_COUNT - 1) * T_COUNT,
                        1'b0);
                add_req(T_ZERO + $urandom_range(0, T_COUNT - 1), rare_end());
            end
            else if (pick == 8)
                add_req(any_point(), rare_end());
            else
            begin
                // broken runs: stray vowel or trailer, lead after lead, a random syllable
                case ($urandom_range(0, 3))
                    0: add_req(V_FIRST + $urandom_range(0, V_COUNT - 1), rare_end());
                    1: add_req(T_ZERO + $urandom_range(0, T_COUNT - 1), rare_end());
                    2: add_req(L_FIRST + $urandom_range(0, L_COUNT - 1), rare_end());
                    default: add_req(any_syllable(), rare_end());
                endcase
            end
        end
    endfunction

    function automatic void queue_decompose_run(input int goal);
        while (stim_count < goal)
        begin
            if ($urandom_range(0, 9) < 7)
                add_req(any_syllable(), rare_end());
            else
                add_req(any_point(), rare_end());
        end
    endfunction

    // ------------------------------------------------------------------
    // test sequence, reset and the final verdict
    // ------------------------------------------------------------------
    initial
    begin
        // decompose: syllables with and without trailer, neighbors of the
        // syllable block, zero and the top of the 21-bit range
        add_mode_write(MODE_DECOMPOSE);
        add_req(32'hAC00, 1'b0);
        add_req(32'hD7A3, 1'b0);
        add_req(32'hABFF, 1'b0);
        add_req(32'hD7A4, 1'b0);
        add_req(32'h0, 1'b0);
        add_req(32'h1FFFFF, 1'b1);
        add_req(32'hAC01, 1'b0);

        // compose: l+v+t, then a new lead releases it; join-only flushed by end
        add_mode_write(MODE_COMPOSE);
        add_req(32'h1100, 1'b0);
        add_req(32'h1161, 1'b0);
        add_req(32'h11A8, 1'b0);
        add_req(32'h1112, 1'b0);
        add_req(32'h1175, 1'b0);
        add_req(32'h11C2, 1'b1);
        // t index zero never joins, a trailer after a trailer never joins
        add_req(32'h1100, 1'b0);
        add_req(32'h1161, 1'b0);
        add_req(32'h11A7, 1'b0);
        add_req(32'h11A8, 1'b0);
        // precomposed lv takes a trailer, a lone point ends the text
        add_req(32'hAC00, 1'b0);
        add_req(32'h11A8, 1'b0);
        add_req(32'h41, 1'b1);
        // join with end set: the joined syllable is the only result
        add_req(32'h1100, 1'b0);
        add_req(32'h1161, 1'b1);
        // leave a lead held, then switch: decompose discards it
        add_req(32'h1100, 1'b0);
        add_mode_write(MODE_DECOMPOSE);
        add_req(32'hD788, 1'b1);

        // random phases through both modes
        add_mode_write(MODE_COMPOSE);
        queue_compose_run(stim_count + 40);
        add_mode_write(MODE_DECOMPOSE);
        queue_decompose_run(stim_count + 25);
        add_mode_write(MODE_COMPOSE);
        queue_compose_run(stim_count + 30);
        add_mode_write(MODE_DECOMPOSE);
        queue_decompose_run(stim_count + 10);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || expected_points.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (expected_points.size() != 0)
            note_fault("results still outstanding at the end");
        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // rising edge: mode shadow, prediction on accepted requests and the
    // result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                compose_mode = cfg_wdata;
            if (req_valid && req_ready)
                normalize_point(req);
            req_fired <= req_valid && req_ready;

            if (res_valid && res_ready)
            begin
                if (expected_points.size() == 0)
                    note_fault($sformatf("unexpected result pt=%h last=%b end=%b",
                                         res.out_point, res.run_last,
                                         res.stream_end_out));
                else
                begin
                    want = expected_points.pop_front();
                    if (res.out_point !== want.out_point ||
                        res.run_last !== want.run_last ||
                        res.stream_end_out !== want.stream_end_out)
                        note_fault($sformatf(
                            "mismatch: expected pt=%h last=%b end=%b, got pt=%h last=%b end=%b",
                            want.out_point, want.run_last, want.stream_end_out,
                            res.out_point, res.run_last, res.stream_end_out));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // request driver, falling edge: bursts with random gaps; mode writes
    // only after the block has drained and settled
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            nxt_we = 1'b0;
            // the request presented last cycle went in at the rising edge
            if (req_valid && req_fired)
                pending_ops.delete(0);
            if (!(req_valid && !req_fired))
            begin
                nxt_valid = 1'b0;
                if (pending_ops.size() != 0)
                begin
                    case (pending_ops[0].kind)
                        ACT_IDLE:
                        begin
                            // hold off until every expected result is out
                            if (expected_points.size() != 0)
                                settle_left = SETTLE_CYCLES;
                            else if (settle_left != 0)
                                settle_left--;
                            else
                            begin
                                pending_ops.delete(0);
                                settle_left = SETTLE_CYCLES;
                            end
                        end
                        ACT_CFG:
                        begin
                            nxt_we = 1'b1;
                            cfg_wdata <= pending_ops[0].mode;
                            pending_ops.delete(0);
                        end
                        default:
                        begin
                            if (gap_left != 0)
                                gap_left--;
                            else
                            begin
                                nxt_valid = 1'b1;
                                req <= pending_ops[0].item;
                                burst_left--;
                                if (burst_left == 0)
                                begin
                                    // occasional long back-to-back stretch
                                    if ($urandom_range(0, 4) == 0)
                                    begin
                                        burst_left = $urandom_range(20, 40);
                                        gap_left = 0;
                                    end
                                    else
                                    begin
                                        burst_left = $urandom_range(1, 8);
                                        gap_left = $urandom_range(0, 6);
                                    end
                                end
                            end
                        end
                    endcase
                end
                req_valid <= nxt_valid;
            end
            cfg_we <= nxt_we;
        end
    end

    // ------------------------------------------------------------------
    // result receiver, falling edge: stall style redrawn at random, paced by a counter of cycles
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            stall_clock++;
            if (stall_clock % 64 == 0)
                stall_style = stall_style_t'($urandom_range(0, 2));
            if (stall_left != 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else if (stall_style == STALL_LIGHT && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 1);
                res_ready <= 1'b0;
            end
            else if (stall_style == STALL_HEAVY && $urandom_range(0, 2) == 0)
            begin
                stall_left = $urandom_range(0, 15);
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

@@ hangul_syllable_normalizer_top.f @@
rtl/hsn_pkg.sv
rtl/hsn_front.sv
rtl/hsn_queue.sv
rtl/hsn_back.sv
rtl/hangul_syllable_normalizer_top.sv
sim/tb_hangul_syllable_normalizer_top.sv
